[hdl/pmx_pkg.sv]
// Shared constants, types and helpers for the PMX crossover block.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none

package pmx_pkg;

  localparam int MAX_LEN  = 64;
  localparam int IDX_W    = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W    = $clog2(MAX_LEN + 1);
  localparam int LABEL_W  = 6;
  localparam int STATUS_W = 2;
  localparam int CMP_W    = (LABEL_W > CNT_W) ? LABEL_W : CNT_W;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [LABEL_W-1:0]  lbl_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_BAD_CUT  = 2'd1;
  localparam status_t ST_NOT_PERM = 2'd2;

  // Requests into the memory bank: one write and one read port per store.
  typedef struct packed {
    logic ab_we;
    idx_t ab_waddr;
    lbl_t a_wdata;
    lbl_t b_wdata;
    idx_t ab_raddr;
    logic pa_we;
    idx_t pa_waddr;
    idx_t pa_wdata;
    idx_t pa_raddr;
    logic pb_we;
    idx_t pb_waddr;
    idx_t pb_wdata;
    idx_t pb_raddr;
    logic ch_we;
    idx_t ch_waddr;
    lbl_t ch_wdata;
    idx_t ch_raddr;
  } mem_req_t;

  // Registered read data, valid in the cycle after the address.
  typedef struct packed {
    lbl_t a;
    lbl_t b;
    idx_t pa;
    idx_t pb;
    lbl_t ch;
  } mem_rsp_t;

  function automatic idx_t lbl2idx(input lbl_t lbl);
    return idx_t'(lbl);
  endfunction

  function automatic logic lbl_ge_len(input lbl_t lbl, input cnt_t len);
    return CMP_W'(lbl) >= CMP_W'(len);
  endfunction

  function automatic logic in_seg(input idx_t p, input idx_t lo, input idx_t hi);
    return (p >= lo) && (p <= hi);
  endfunction

endpackage

`default_nettype wire

[hdl/pmx_channels.sv]
// Valid/ready channel interfaces: parent pairs in, child words out.
// Depends on pmx_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pmx_pair_if;
  import pmx_pkg::*;
  logic valid;
  logic ready;
  lbl_t elem_a;
  lbl_t elem_b;
  lbl_t cut_first;
  lbl_t cut_last;
  logic last;

  modport source (output valid, elem_a, elem_b, cut_first, cut_last, last, input ready);
  modport sink   (input valid, elem_a, elem_b, cut_first, cut_last, last, output ready);
endinterface

interface pmx_child_if;
  import pmx_pkg::*;
  logic    valid;
  logic    ready;
  lbl_t    child_elem;
  lbl_t    child_pos;
  status_t status;
  logic    end_of_child;

  modport source (output valid, child_elem, child_pos, status, end_of_child, input ready);
  modport sink   (input valid, child_elem, child_pos, status, end_of_child, output ready);
endinterface

`default_nettype wire

[hdl/pmx_mem_bank.sv]
// Memory bank: parents by position, label positions, child by position.
// Depends on pmx_pkg. All reads are registered.
`timescale 1ns / 1ps
`default_nettype none

module pmx_mem_bank (
  input  wire pmx_pkg::mem_req_t req,
  input  wire                    clk,
  output pmx_pkg::mem_rsp_t      rsp
);
  import pmx_pkg::*;

  lbl_t mem_a  [MAX_LEN];
  lbl_t mem_b  [MAX_LEN];
  idx_t mem_pa [MAX_LEN];
  idx_t mem_pb [MAX_LEN];
  lbl_t mem_ch [MAX_LEN];

  // Read data of an entry written in the same cycle is never used, so no bypass.
  always_ff @(posedge clk) begin
    if (req.ab_we) begin
      mem_a[req.ab_waddr] <= req.a_wdata;
      mem_b[req.ab_waddr] <= req.b_wdata;
    end
    if (req.pa_we) begin
      mem_pa[req.pa_waddr] <= req.pa_wdata;
    end
    if (req.pb_we) begin
      mem_pb[req.pb_waddr] <= req.pb_wdata;
    end
    if (req.ch_we) begin
      mem_ch[req.ch_waddr] <= req.ch_wdata;
    end
    rsp.a  <= mem_a[req.ab_raddr];
    rsp.b  <= mem_b[req.ab_raddr];
    rsp.pa <= mem_pa[req.pa_raddr];
    rsp.pb <= mem_pb[req.pb_raddr];
    rsp.ch <= mem_ch[req.ch_raddr];
  end

endmodule

`default_nettype wire

[hdl/pmx_permutation_crossover_top.sv]
// Top level of the partially mapped crossover (PMX) block: sequencer,
// per-job mark vectors and output register. Depends on pmx_pkg,
// pmx_channels and pmx_mem_bank.
//
//   channel | dir | fields                                        | word
//   --------+-----+-----------------------------------------------+------------------
//   pairs   | in  | elem_a, elem_b, cut_first, cut_last, last     | one parent pair
//   child   | out | child_elem, child_pos, status, end_of_child   | one child label
//
// Steps: pairs load one word per cycle while pairs.ready is high. The last
//   word starts the job: a permutation check per position (read, evaluate),
//   then per segment position a read, evaluate and map step plus a walk step
//   for each extra mapping hop, then per child word a memory read, then the
//   output register. Error jobs go to the error state after the failing check
//   or the last pair, then load their single word.
// pairs.ready is low from the last pair until the final word of the job is
//   in the output register; each memory gives one read per cycle and the
//   sequencer waits on every read, which sets this pace.
// Reset (rst, synchronous) clears control state and the mark vectors;
//   there is no clearing pass. A stall on child holds the sequencer only
//   in the emit and error states.
`timescale 1ns / 1ps
`default_nettype none

module pmx_permutation_crossover_top (
  input wire          clk,
  input wire          rst,
  pmx_pair_if.sink    pairs,
  pmx_child_if.source child
);
  import pmx_pkg::*;

  localparam logic [3:0] S_LOAD    = 4'd0;
  localparam logic [3:0] S_CHK_RD  = 4'd1;
  localparam logic [3:0] S_CHK_EV  = 4'd2;
  localparam logic [3:0] S_SEG_RD  = 4'd3;
  localparam logic [3:0] S_SEG_EV  = 4'd4;
  localparam logic [3:0] S_SEG_MAP = 4'd5;
  localparam logic [3:0] S_WALK_A  = 4'd6;
  localparam logic [3:0] S_WALK_B  = 4'd7;
  localparam logic [3:0] S_WALK_C  = 4'd8;
  localparam logic [3:0] S_EMIT_RD = 4'd9;
  localparam logic [3:0] S_EMIT_WR = 4'd10;
  localparam logic [3:0] S_ERR     = 4'd11;

  logic [3:0] state, state_next;
  cnt_t       load_count, load_count_next;
  cnt_t       len, len_next;
  idx_t       lo, lo_next, hi, hi_next;
  idx_t       i, i_next;          // position cursor: check, segment, emit
  idx_t       now, now_next;      // mapping walk position
  lbl_t       bi, bi_next;        // parent B label being placed
  status_t    err_code, err_next;

  // Per-job marks: labels seen in A, labels seen in B, child positions placed.
  logic [MAX_LEN-1:0] seen_a, seen_a_next;
  logic [MAX_LEN-1:0] seen_b, seen_b_next;
  logic [MAX_LEN-1:0] placed, placed_next;

  logic    out_valid;
  lbl_t    out_elem, out_elem_next;
  lbl_t    out_pos, out_pos_next;
  status_t out_status, out_status_next;
  logic    out_end, out_end_next;
  logic    out_load;
  logic    out_free;

  mem_req_t req;
  mem_rsp_t rsp;

  logic in_acc;
  cnt_t len_new;
  lbl_t cut_lo, cut_hi;
  logic last_pos;

  pmx_mem_bank u_mem (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

  assign pairs.ready = (state == S_LOAD);
  assign in_acc      = pairs.valid && pairs.ready;
  assign out_free    = !out_valid || child.ready;

  // Count saturates at MAX_LEN; extra pairs are dropped.
  assign len_new  = (load_count < CNT_W'(MAX_LEN)) ? load_count + CNT_W'(1) : load_count;
  assign cut_lo   = (pairs.cut_first > pairs.cut_last) ? pairs.cut_last : pairs.cut_first;
  assign cut_hi   = (pairs.cut_first > pairs.cut_last) ? pairs.cut_first : pairs.cut_last;
  assign last_pos = (CNT_W'(i) == len - CNT_W'(1));

  always_comb begin
    state_next      = state;
    load_count_next = load_count;
    len_next        = len;
    lo_next         = lo;
    hi_next         = hi;
    i_next          = i;
    now_next        = now;
    bi_next         = bi;
    err_next        = err_code;
    seen_a_next     = seen_a;
    seen_b_next     = seen_b;
    placed_next     = placed;
    out_load        = 1'b0;
    out_elem_next   = out_elem;
    out_pos_next    = out_pos;
    out_status_next = out_status;
    out_end_next    = out_end;

    req          = '0;
    req.ab_waddr = load_count[IDX_W-1:0];
    req.a_wdata  = pairs.elem_a;
    req.b_wdata  = pairs.elem_b;
    req.ab_raddr = (state == S_WALK_A) ? now : i;
    req.pa_raddr = lbl2idx(rsp.b);   // position in A of B's label
    req.pb_raddr = lbl2idx(rsp.a);   // position in B of A's label
    req.ch_raddr = i;
    req.pa_waddr = lbl2idx(rsp.a);
    req.pa_wdata = i;
    req.pb_waddr = lbl2idx(rsp.b);
    req.pb_wdata = i;
    req.ch_waddr = i;
    req.ch_wdata = rsp.a;

    unique case (state)
      S_LOAD: begin
        if (in_acc) begin
          req.ab_we       = (load_count < CNT_W'(MAX_LEN));
          load_count_next = len_new;
          if (pairs.last) begin
            load_count_next = '0;
            len_next        = len_new;
            lo_next         = idx_t'(cut_lo);
            hi_next         = idx_t'(cut_hi);
            i_next          = '0;
            if (lbl_ge_len(cut_hi, len_new)) begin
              err_next   = ST_BAD_CUT;
              state_next = S_ERR;
            end else begin
              state_next = S_CHK_RD;
            end
          end
        end
      end

      S_CHK_RD: begin
        state_next = S_CHK_EV;
      end

      S_CHK_EV: begin
        if (lbl_ge_len(rsp.a, len) || lbl_ge_len(rsp.b, len) ||
            seen_a[lbl2idx(rsp.a)] || seen_b[lbl2idx(rsp.b)]) begin
          err_next   = ST_NOT_PERM;
          state_next = S_ERR;
        end else begin
          seen_a_next[lbl2idx(rsp.a)] = 1'b1;
          seen_b_next[lbl2idx(rsp.b)] = 1'b1;
          req.pa_we = 1'b1;
          req.pb_we = 1'b1;
          if (last_pos) begin
            i_next     = lo;
            state_next = S_SEG_RD;
          end else begin
            i_next     = i + IDX_W'(1);
            state_next = S_CHK_RD;
          end
        end
      end

      S_SEG_RD: begin
        state_next = S_SEG_EV;
      end

      // Child takes A's label inside the segment; launch both map lookups.
      S_SEG_EV: begin
        req.ch_we      = 1'b1;
        placed_next[i] = 1'b1;
        bi_next        = rsp.b;
        state_next     = S_SEG_MAP;
      end

      S_SEG_MAP: begin
        if (!in_seg(rsp.pa, lo, hi)) begin
          now_next = rsp.pb;
          if (in_seg(rsp.pb, lo, hi)) begin
            state_next = S_WALK_A;
          end else begin
            req.ch_we            = 1'b1;
            req.ch_waddr         = rsp.pb;
            req.ch_wdata         = bi;
            placed_next[rsp.pb]  = 1'b1;
          end
        end
        if (state_next != S_WALK_A) begin
          if (i == hi) begin
            i_next     = '0;
            state_next = S_EMIT_RD;
          end else begin
            i_next     = i + IDX_W'(1);
            state_next = S_SEG_RD;
          end
        end
      end

      S_WALK_A: begin
        state_next = S_WALK_B;
      end

      S_WALK_B: begin
        state_next = S_WALK_C;
      end

      S_WALK_C: begin
        now_next = rsp.pb;
        if (in_seg(rsp.pb, lo, hi)) begin
          state_next = S_WALK_A;
        end else begin
          req.ch_we           = 1'b1;
          req.ch_waddr        = rsp.pb;
          req.ch_wdata        = bi;
          placed_next[rsp.pb] = 1'b1;
          if (i == hi) begin
            i_next     = '0;
            state_next = S_EMIT_RD;
          end else begin
            i_next     = i + IDX_W'(1);
            state_next = S_SEG_RD;
          end
        end
      end

      S_EMIT_RD: begin
        state_next = S_EMIT_WR;
      end

      // Unplaced positions fall back to parent B's label.
      S_EMIT_WR: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_elem_next   = placed[i] ? rsp.ch : rsp.b;
          out_pos_next    = lbl_t'(i);
          out_status_next = ST_OK;
          out_end_next    = last_pos;
          if (last_pos) begin
            seen_a_next = '0;
            seen_b_next = '0;
            placed_next = '0;
            state_next  = S_LOAD;
          end else begin
            i_next     = i + IDX_W'(1);
            state_next = S_EMIT_RD;
          end
        end
      end

      S_ERR: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_elem_next   = '0;
          out_pos_next    = '0;
          out_status_next = err_code;
          out_end_next    = 1'b1;
          seen_a_next     = '0;
          seen_b_next     = '0;
          placed_next     = '0;
          state_next      = S_LOAD;
        end
      end

      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      load_count <= '0;
      seen_a     <= '0;
      seen_b     <= '0;
      placed     <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      load_count <= load_count_next;
      seen_a     <= seen_a_next;
      seen_b     <= seen_b_next;
      placed     <= placed_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (child.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    len        <= len_next;
    lo         <= lo_next;
    hi         <= hi_next;
    i          <= i_next;
    now        <= now_next;
    bi         <= bi_next;
    err_code   <= err_next;
    out_elem   <= out_elem_next;
    out_pos    <= out_pos_next;
    out_status <= out_status_next;
    out_end    <= out_end_next;
  end

  assign child.valid        = out_valid;
  assign child.child_elem   = out_elem;
  assign child.child_pos    = out_pos;
  assign child.status       = out_status;
  assign child.end_of_child = out_end;

endmodule

`default_nettype wire

[hdl/pmx_checker.sv]
// Port-level checks for the PMX crossover top, bound to it below.
// Depends on pmx_pkg and pmx_permutation_crossover_top.
`timescale 1ns / 1ps
`default_nettype none

module pmx_checker (
  input wire                  clk,
  input wire                  rst,
  input wire                  in_valid,
  input wire                  in_ready,
  input wire                  in_last,
  input wire                  out_valid,
  input wire                  out_ready,
  input wire [5:0]            child_elem,
  input wire [5:0]            child_pos,
  input wire pmx_pkg::status_t status,
  input wire                  end_of_child
);
  import pmx_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output word valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(child_elem) && $stable(child_pos)
                                && $stable(status) && $stable(end_of_child))
    else $error("stalled child word changed");

  a_error_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> end_of_child && (child_pos == 6'd0)
                                       && (child_elem == 6'd0))
    else $error("error word is not a lone zero word");

  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("pairs taken while crossover is running");

endmodule

bind pmx_permutation_crossover_top pmx_checker u_pmx_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (pairs.valid),
  .in_ready     (pairs.ready),
  .in_last      (pairs.last),
  .out_valid    (child.valid),
  .out_ready    (child.ready),
  .child_elem   (child.child_elem),
  .child_pos    (child.child_pos),
  .status       (child.status),
  .end_of_child (child.end_of_child)
);

`default_nettype wire
